// ----- rtl/prt_pkg.sv -----
package prt_pkg;

	// default table size
	localparam int DEF_TABLE_DEPTH = 16;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 10;
	localparam int WILD_W = 6;
	localparam int STAT_W = 2;

	// wildcard count that ignores the whole address
	localparam logic [WILD_W-1:0] MAX_WILD = 6'd32;
	localparam logic [ADDR_W-1:0] ALL_ONES = '1;

	// action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_LOOKUP = 2'd0,
		STAT_INSERT = 2'd1,
		STAT_UPDATE = 2'd2,
		STAT_FULL   = 2'd3
	} prt_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR
	} prt_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [WILD_W-1:0] wild;
	} prt_entry_t;

	// compare unit results
	typedef struct packed {
		logic match;
		logic ahead;
		logic same;
	} prt_cmp_t;

endpackage

// ----- rtl/prt_mem.sv -----
module prt_mem
	import prt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] wr_addr,
	input  prt_entry_t       wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output prt_entry_t       rd_data
);

	prt_entry_t mem [TABLE_DEPTH];
	prt_entry_t rd_data_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/prt_cmp.sv -----
module prt_cmp
	import prt_pkg::*;
(
	input  prt_entry_t        entry,
	input  logic [ADDR_W-1:0] key_addr,
	input  logic [WILD_W-1:0] key_wild,
	output prt_cmp_t          res
);

	logic [ADDR_W-1:0] mask;

	// prefix mask of the stored entry, empty at full wildcard
	always_comb begin
		if (entry.wild >= MAX_WILD) begin
			mask = '0;
		end else begin
			mask = ALL_ONES << entry.wild;
		end
	end

	// masked match for lookup, sort order and identity for insert
	always_comb begin
		res.match = ((entry.addr & mask) == (key_addr & mask));
		if (entry.wild != key_wild) begin
			res.ahead = (entry.wild < key_wild);
		end else begin
			res.ahead = (entry.addr < key_addr);
		end
		res.same = (entry.wild == key_wild) && (entry.addr == key_addr);
	end

endmodule

// ----- rtl/prefix_route_table_core.sv -----
// Longest prefix match table. Pulse start while busy is low to hand in one
// beat: action 0 inserts or updates an entry, action 1 looks up a route.
// Exactly one result beat follows, shown on the result ports for a single
// cycle while done is high; the receiver cannot hold it off, so capture it
// on that cycle. Entries sit in a memory with one write port and one
// registered read port and are visited one at a time by one compare unit: a
// lookup reads and compares entries in order until one matches or none is
// left; an insert compares entries until one is not ahead of the key or none
// is left, then updates a same entry in place, reports a full table, or
// moves the later entries up one place each and writes the new entry.
// Done rises as busy drops. No clearing pass is needed after reset.
module prefix_route_table_core
	import prt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [ADDR_W-1:0] address,
	input  logic [PORT_W-1:0] egress_port,
	input  logic [WILD_W-1:0] wildcard_bits,
	output logic              done,
	output logic              hit,
	output logic [PORT_W-1:0] route_port,
	output logic [WILD_W-1:0] matched_wildcard,
	output logic [STAT_W-1:0] status,
	output logic [CNT_W-1:0]  entry_count
);

	prt_state_t state_q, state_d;

	logic              act_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PORT_W-1:0] port_q;
	logic [WILD_W-1:0] wild_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  sh_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  sh_prev;

	logic              done_q;
	logic              hit_q;
	logic [PORT_W-1:0] route_port_q;
	logic [WILD_W-1:0] matched_wild_q;
	prt_status_t       status_q;
	logic [CNT_W-1:0]  entry_count_q;

	logic        accept;
	logic        full;
	logic        scan_end;
	logic        shift_end;

	logic        idx_inc;
	logic        ld_sh;
	logic        sh_dec;
	logic        cnt_inc;
	logic        fin;
	logic        fin_hit;
	prt_status_t fin_status;

	logic             we;
	logic [IDX_W-1:0] wr_addr;
	prt_entry_t       wr_data;
	logic [IDX_W-1:0] rd_addr;
	prt_entry_t       rd_data;
	prt_entry_t       ins_entry;
	prt_cmp_t         cmp;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));
	assign scan_end  = (idx_q == count_q);
	assign shift_end = (sh_q == idx_q);
	assign sh_prev   = sh_q - 1'b1;
	assign ins_entry = '{addr: addr_q, port: port_q, wild: wild_q};

	prt_mem #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	prt_cmp u_cmp (
		.entry   (rd_data),
		.key_addr(addr_q),
		.key_wild(wild_q),
		.res     (cmp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (!scan_end) begin
					state_d = ST_SCAN_CHK;
				end else if (act_q == ACT_LOOKUP || full) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_SCAN_CHK: begin
				if (act_q == ACT_LOOKUP) begin
					state_d = cmp.match ? ST_IDLE : ST_SCAN_RD;
				end else if (cmp.ahead) begin
					state_d = ST_SCAN_RD;
				end else if (cmp.same || full) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_SHIFT_RD: begin
				state_d = shift_end ? ST_IDLE : ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				state_d = ST_SHIFT_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs: memory access, counters and result
	always_comb begin
		idx_inc    = 1'b0;
		ld_sh      = 1'b0;
		sh_dec     = 1'b0;
		cnt_inc    = 1'b0;
		fin        = 1'b0;
		fin_hit    = 1'b0;
		fin_status = STAT_LOOKUP;
		we         = 1'b0;
		wr_addr    = idx_q[IDX_W-1:0];
		wr_data    = ins_entry;
		rd_addr    = idx_q[IDX_W-1:0];
		case (state_q)
			ST_SCAN_RD: begin
				if (scan_end) begin
					if (act_q == ACT_LOOKUP) begin
						fin = 1'b1;
					end else if (full) begin
						fin        = 1'b1;
						fin_status = STAT_FULL;
					end else begin
						ld_sh = 1'b1;
					end
				end
			end
			ST_SCAN_CHK: begin
				if (act_q == ACT_LOOKUP) begin
					if (cmp.match) begin
						fin     = 1'b1;
						fin_hit = 1'b1;
					end else begin
						idx_inc = 1'b1;
					end
				end else if (cmp.ahead) begin
					idx_inc = 1'b1;
				end else if (cmp.same) begin
					we         = 1'b1;
					fin        = 1'b1;
					fin_status = STAT_UPDATE;
				end else if (full) begin
					fin        = 1'b1;
					fin_status = STAT_FULL;
				end else begin
					ld_sh = 1'b1;
				end
			end
			ST_SHIFT_RD: begin
				rd_addr = sh_prev[IDX_W-1:0];
				if (shift_end) begin
					we         = 1'b1;
					cnt_inc    = 1'b1;
					fin        = 1'b1;
					fin_status = STAT_INSERT;
				end
			end
			ST_SHIFT_WR: begin
				we      = 1'b1;
				wr_addr = sh_q[IDX_W-1:0];
				wr_data = rd_data;
				sh_dec  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cnt_inc) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// item key and scan pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			addr_q <= address;
			port_q <= egress_port;
			wild_q <= (wildcard_bits > MAX_WILD) ? MAX_WILD : wildcard_bits;
			idx_q  <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (ld_sh) begin
			sh_q <= count_q;
		end else if (sh_dec) begin
			sh_q <= sh_prev;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (fin) begin
			hit_q          <= fin_hit;
			route_port_q   <= fin_hit ? rd_data.port : '0;
			matched_wild_q <= fin_hit ? rd_data.wild : '0;
			status_q       <= fin_status;
			entry_count_q  <= cnt_inc ? count_q + 1'b1 : count_q;
		end
	end

	assign done             = done_q;
	assign hit              = hit_q;
	assign route_port       = route_port_q;
	assign matched_wildcard = matched_wild_q;
	assign status           = status_q;
	assign entry_count      = entry_count_q;

endmodule
